// File: rtl/rat_pkg.sv
// Shared types, codes and constants of the region address translator.
package rat_pkg;

  // Default table depth.
  localparam int unsigned REGION_SLOTS_DEFAULT = 16;

  // Field widths.
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned PROT_W = 3;
  localparam int unsigned STAT_W = 2;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_MAP       = 3'd0,
    CMD_UNMAP     = 3'd1,
    CMD_CLEAR     = 3'd2,
    CMD_TRANSLATE = 3'd3,
    CMD_PROBE     = 3'd4,
    CMD_CHECK     = 3'd5
  } cmd_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FAULT = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Region flag bits.
  localparam logic [PROT_W-1:0] FLAG_READ  = 3'h1;
  localparam logic [PROT_W-1:0] FLAG_WRITE = 3'h2;
  localparam logic [PROT_W-1:0] FLAG_EXEC  = 3'h4;

  // Access kinds checked on translate.
  localparam logic [PROT_W-1:0] ACC_READ  = 3'd0;
  localparam logic [PROT_W-1:0] ACC_WRITE = 3'd1;
  localparam logic [PROT_W-1:0] ACC_EXEC  = 3'd2;

  // One table entry.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] phys;
    logic [ADDR_W-1:0] length;
    logic [PROT_W-1:0] flags;
  } region_t;

  // Table update request from the sequencer.
  typedef struct packed {
    logic write;
    logic invalidate;
    logic clear_all;
  } mem_op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_OFFSET,
    S_RANGE,
    S_DONE
  } state_e;

endpackage

// File: rtl/rat_ifs.sv
// Valid/ready channel interfaces for command and result beats.
interface rat_in_if import rat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] virtual_addr;
  logic [ADDR_W-1:0] physical_base;
  logic [ADDR_W-1:0] region_size;
  logic [PROT_W-1:0] protection;
  logic [PROT_W-1:0] access_code;

  modport source (
    output valid, command, virtual_addr, physical_base, region_size, protection,
           access_code,
    input  ready
  );
  modport sink (
    input  valid, command, virtual_addr, physical_base, region_size, protection,
           access_code,
    output ready
  );
endinterface

interface rat_out_if import rat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] physical_addr;
  logic              answer;

  modport source (
    output valid, status, physical_addr, answer,
    input  ready
  );
  modport sink (
    input  valid, status, physical_addr, answer,
    output ready
  );
endinterface

// File: rtl/rat_mem.sv
// Region table: entry memory with registered read, valid bits in flops.
module rat_mem import rat_pkg::*; #(
  parameter int unsigned REGION_SLOTS = REGION_SLOTS_DEFAULT,
  localparam int unsigned IdxW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output logic            rd_valid_o,
  output region_t         rd_region_o,
  input  mem_op_t         op_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  region_t         wr_region_i
);

  logic [REGION_SLOTS-1:0] valid_q;
  region_t                 mem_q [REGION_SLOTS];
  region_t                 rd_region_q;
  logic                    rd_valid_q;

  // Valid bits: reset and clear drop all entries at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (op_i.clear_all) begin
      valid_q <= '0;
    end else if (op_i.write) begin
      valid_q[wr_idx_i] <= 1'b1;
    end else if (op_i.invalidate) begin
      valid_q[wr_idx_i] <= 1'b0;
    end
  end

  // Entry write port
  always_ff @(posedge clk_i) begin
    if (op_i.write) begin
      mem_q[wr_idx_i] <= wr_region_i;
    end
  end

  // Registered read port, valid bit sampled alongside
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_region_q <= mem_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (rd_en_i) begin
      rd_valid_q <= valid_q[rd_idx_i];
    end
  end

  assign rd_valid_o  = rd_valid_q;
  assign rd_region_o = rd_region_q;

endmodule

// File: rtl/rat_ctrl.sv
// Command sequencer: table scan, floor lookup, range check and result register.
module rat_ctrl import rat_pkg::*; #(
  parameter int unsigned REGION_SLOTS = REGION_SLOTS_DEFAULT,
  localparam int unsigned IdxW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            enable_i,
  rat_in_if.sink          in_i,
  rat_out_if.source       out_o,
  output logic            rd_en_o,
  output logic [IdxW-1:0] rd_idx_o,
  input  logic            rd_valid_i,
  input  region_t         rd_region_i,
  output mem_op_t         op_o,
  output logic [IdxW-1:0] wr_idx_o,
  output region_t         wr_region_o
);

  localparam int unsigned CntW = $clog2(REGION_SLOTS + 1);
  localparam logic [CntW-1:0] CntEnd = CntW'(REGION_SLOTS);

  state_e            state_q, state_d;
  cmd_e              cmd_q;
  logic [ADDR_W-1:0] addr_q, base_q, size_q;
  logic [PROT_W-1:0] prot_q, acc_q;

  logic [CntW-1:0]   cnt_q;
  logic              pipe_q;
  logic [IdxW-1:0]   pidx_q;

  logic              exact_found_q, free_found_q, best_found_q;
  logic [IdxW-1:0]   exact_idx_q, free_idx_q;
  region_t           best_q;

  logic [ADDR_W-1:0] off_q, sum_q;
  logic              hit_q;

  logic              out_valid_q;
  status_e           status_q;
  logic [ADDR_W-1:0] phys_q;
  logic              answer_q;

  logic              accept, out_free, finish, rd_en;
  logic              take_exact, take_free, take_best, hit, denied;
  mem_op_t           op;
  logic [IdxW-1:0]   wr_idx;
  status_e           res_status;
  logic [ADDR_W-1:0] res_phys;
  logic              res_answer;

  assign accept   = (state_q == S_IDLE) && in_i.valid;
  assign out_free = !out_valid_q || out_o.ready;

  // Per-slot scan decisions on the beat coming back from the table
  assign take_exact = pipe_q && rd_valid_i && !exact_found_q && (rd_region_i.start == addr_q);
  assign take_free  = pipe_q && !rd_valid_i && !free_found_q;
  assign take_best  = pipe_q && rd_valid_i && (rd_region_i.start <= addr_q) &&
                      (!best_found_q || (rd_region_i.start > best_q.start));

  // Access check on the selected region
  assign hit    = best_found_q && hit_q;
  assign denied = ((acc_q == ACC_READ)  && ((best_q.flags & FLAG_READ)  == '0)) ||
                  ((acc_q == ACC_WRITE) && ((best_q.flags & FLAG_WRITE) == '0)) ||
                  ((acc_q == ACC_EXEC)  && ((best_q.flags & FLAG_EXEC)  == '0));

  // Next state, table requests and result
  always_comb begin
    state_d    = state_q;
    rd_en      = 1'b0;
    finish     = 1'b0;
    op         = '0;
    wr_idx     = exact_found_q ? exact_idx_q : free_idx_q;
    res_status = ST_OK;
    res_phys   = '0;
    res_answer = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          case (cmd_e'(in_i.command))
            CMD_MAP, CMD_UNMAP, CMD_PROBE, CMD_CHECK: state_d = S_SCAN;
            CMD_TRANSLATE: state_d = enable_i ? S_SCAN : S_DONE;
            default:       state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        rd_en = (cnt_q != CntEnd);
        if (cnt_q == CntEnd) begin
          state_d = S_OFFSET;
        end
      end
      S_OFFSET: state_d = S_RANGE;
      S_RANGE:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          finish  = 1'b1;
          state_d = S_IDLE;
          case (cmd_q)
            CMD_MAP: begin
              if (exact_found_q || free_found_q) begin
                op.write = 1'b1;
              end else begin
                res_status = ST_FULL;
              end
            end
            CMD_UNMAP: op.invalidate = exact_found_q;
            CMD_CLEAR: op.clear_all  = 1'b1;
            CMD_TRANSLATE: begin
              if (!enable_i) begin
                res_phys = addr_q;
              end else if (!hit) begin
                res_status = ST_MISS;
              end else if (denied) begin
                res_status = ST_FAULT;
              end else begin
                res_phys = sum_q;
              end
            end
            CMD_PROBE: res_answer = exact_found_q;
            CMD_CHECK: res_answer = hit && ((best_q.flags & acc_q) == acc_q);
            default: ;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      pipe_q        <= 1'b0;
      exact_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      best_found_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pipe_q  <= rd_en;
      if (accept) begin
        cnt_q         <= '0;
        exact_found_q <= 1'b0;
        free_found_q  <= 1'b0;
        best_found_q  <= 1'b0;
      end else begin
        if (rd_en) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (take_exact) exact_found_q <= 1'b1;
        if (take_free)  free_found_q  <= 1'b1;
        if (take_best)  best_found_q  <= 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(in_i.command);
      addr_q <= in_i.virtual_addr;
      base_q <= in_i.physical_base;
      size_q <= in_i.region_size;
      prot_q <= in_i.protection;
      acc_q  <= in_i.access_code;
    end
    if (rd_en) begin
      pidx_q <= cnt_q[IdxW-1:0];
    end
    if (take_exact) exact_idx_q <= pidx_q;
    if (take_free)  free_idx_q  <= pidx_q;
    if (take_best)  best_q      <= rd_region_i;
    // offset into the floor region, then range test and translated address
    if (state_q == S_OFFSET) begin
      off_q <= addr_q - best_q.start;
    end
    if (state_q == S_RANGE) begin
      hit_q <= (off_q < best_q.length);
      sum_q <= best_q.phys + off_q;
    end
    if (finish) begin
      status_q <= res_status;
      phys_q   <= res_phys;
      answer_q <= res_answer;
    end
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.physical_addr = phys_q;
  assign out_o.answer        = answer_q;

  assign rd_en_o     = rd_en;
  assign rd_idx_o    = cnt_q[IdxW-1:0];
  assign op_o        = op;
  assign wr_idx_o    = wr_idx;
  assign wr_region_o = '{start: addr_q, phys: base_q, length: size_q, flags: prot_q};

endmodule

// File: rtl/region_address_translator.sv
// Region address translator top level: enable register, sequencer and region table.
// Table commands scan every slot, one slot read per cycle over the single table read port,
// then compute the offset and the range check before the result is registered; clear,
// unknown commands and translate with translation off skip the scan. A new command is
// accepted once the previous result sits in the result register; input is ready in idle only.
// Reset: all slots invalid, translation disabled; no clearing pass is needed.
module region_address_translator import rat_pkg::*; #(
  parameter int unsigned REGION_SLOTS = REGION_SLOTS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  rat_in_if.sink    in_i,
  rat_out_if.source out_o
);

  localparam int unsigned IdxW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

  logic            enable_q;
  logic            rd_en;
  logic [IdxW-1:0] rd_idx;
  logic            rd_valid;
  region_t         rd_region;
  mem_op_t         op;
  logic [IdxW-1:0] wr_idx;
  region_t         wr_region;

  // Translation enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  rat_ctrl #(
    .REGION_SLOTS (REGION_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (enable_q),
    .in_i        (in_i),
    .out_o       (out_o),
    .rd_en_o     (rd_en),
    .rd_idx_o    (rd_idx),
    .rd_valid_i  (rd_valid),
    .rd_region_i (rd_region),
    .op_o        (op),
    .wr_idx_o    (wr_idx),
    .wr_region_o (wr_region)
  );

  rat_mem #(
    .REGION_SLOTS (REGION_SLOTS)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (rd_en),
    .rd_idx_i    (rd_idx),
    .rd_valid_o  (rd_valid),
    .rd_region_o (rd_region),
    .op_i        (op),
    .wr_idx_i    (wr_idx),
    .wr_region_i (wr_region)
  );

endmodule
